// ===== hw/rtl/bbr_pkg.sv =====
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared types, constants and helpers of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bbr_pkg;

   // Frame limits (defaults of the top-level parameters)
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 2048;

   // Configuration registers
   localparam int          CFG_W          = 12;
   localparam int          CSR_ADDR_W     = 3;
   localparam int          CSR_DATA_W     = 32;
   localparam logic [0:0]  REG_IMG_WIDTH  = 1'b0;
   localparam logic [0:0]  REG_IMG_HEIGHT = 1'b1;
   localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

   // Item kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // Pixel packing: red [23:16], green [15:8], blue [7:0]
   localparam int PIX_W   = 24;
   localparam int CHAN_W  = 8;
   localparam int NCHAN   = 3;
   localparam int CSUM_W  = 10;   // three 8-bit values
   localparam int WSUM_W  = 12;   // nine 8-bit values

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

   // floor(s * 7282 / 2^16) == floor(s / 9) for every s up to 9 * 255
   localparam logic [13:0] RECIP_9 = 14'd7282;

   // Per-item position flags, worked out when the item arrives
   typedef struct packed {
      logic use_above;   // row two above lies inside the frame
      logic use_mid;     // row above lies inside the frame
      logic use_cur;     // arriving row lies inside the frame
      logic col_first;   // item arrives at column zero
      logic emit;        // item releases a result
      logic last;        // result closes the frame
   } pos_type;

   function automatic logic [CHAN_W-1:0] div9(input logic [WSUM_W-1:0] s);
      logic [25:0] p;
      p = 26'(s) * 26'(RECIP_9);
      return p[23:16];
   endfunction

endpackage

// ===== hw/rtl/bbr_ram.sv =====
// ----------------------------------------------------------------------------
// bbr_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module bbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, hold while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bbr_position.sv =====
// ----------------------------------------------------------------------------
// bbr_position
// Column and row counters of the arriving item, frame size clamping and the
// per-item window flags.
// ----------------------------------------------------------------------------
module bbr_position #(
   parameter int MAX_WIDTH  = bbr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bbr_pkg::MAX_HEIGHT_DEF,
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [bbr_pkg::CFG_W-1:0] cfg_width,
   input  logic [bbr_pkg::CFG_W-1:0] cfg_height,
   input  logic                     restart,
   input  logic                     advance,
   output logic [COL_W-1:0]         col_addr,
   output bbr_pkg::pos_type         pos
);
   import bbr_pkg::*;

   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
   localparam int WD_W  = $clog2(MAX_WIDTH + 1);
   localparam int HD_W  = $clog2(MAX_HEIGHT + 1);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WD_W-1:0]  w_eff;
   logic [HD_W-1:0]  h_eff;
   logic [31:0]      w_wide, h_wide, row_wide, h_plus1, col_plus1;
   logic             row_wrap;

   // Clamp frame size to one .. maximum
   always_comb begin
      w_wide = 32'(cfg_width);
      h_wide = 32'(cfg_height);
      if (w_wide == 32'd0) begin
         w_eff = WD_W'(1);
      end else if (w_wide > 32'(MAX_WIDTH)) begin
         w_eff = WD_W'(MAX_WIDTH);
      end else begin
         w_eff = WD_W'(w_wide);
      end
      if (h_wide == 32'd0) begin
         h_eff = HD_W'(1);
      end else if (h_wide > 32'(MAX_HEIGHT)) begin
         h_eff = HD_W'(MAX_HEIGHT);
      end else begin
         h_eff = HD_W'(h_wide);
      end
   end

   // Window flags of the arriving item
   always_comb begin
      row_wide      = 32'(row_ff);
      h_plus1       = 32'(h_eff) + 32'd1;
      pos.use_above = (row_wide >= 32'd2) && (row_wide < h_plus1 + 32'd1);
      pos.use_mid   = (row_wide >= 32'd1) && (row_wide < h_plus1);
      pos.use_cur   = row_wide < 32'(h_eff);
      pos.col_first = col_ff == '0;
      pos.emit      = pos.col_first ? (row_wide >= 32'd2) : (row_wide >= 32'd1);
      pos.last      = pos.col_first && (row_wide >= h_plus1);
   end

   // Advance the raster position
   always_comb begin
      col_plus1 = 32'(col_ff) + 32'd1;
      row_wrap  = col_plus1 >= 32'(w_eff);
      col_in    = col_ff;
      row_in    = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (advance) begin
         if (pos.last) begin
            col_in = '0;
            row_in = '0;
         end else if (row_wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = COL_W'(col_plus1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col_addr = col_ff;

endmodule

// ===== hw/rtl/bbr_window.sv =====
// ----------------------------------------------------------------------------
// bbr_window
// Sliding 3x3 window held as per-channel column sums, and the mean of the
// window divided by nine.
// ----------------------------------------------------------------------------
module bbr_window (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  bbr_pkg::pos_type           pos,
   input  logic [bbr_pkg::PIX_W-1:0]  above_pix,
   input  logic [bbr_pkg::PIX_W-1:0]  mid_pix,
   input  logic [bbr_pkg::PIX_W-1:0]  cur_pix,
   output logic [bbr_pkg::CHAN_W-1:0] mean_red,
   output logic [bbr_pkg::CHAN_W-1:0] mean_green,
   output logic [bbr_pkg::CHAN_W-1:0] mean_blue
);
   import bbr_pkg::*;

   // Two newest column sums per channel; index 0 is blue
   logic [CSUM_W-1:0] colm_ff [NCHAN];
   logic [CSUM_W-1:0] colm_in [NCHAN];
   logic [CSUM_W-1:0] coln_ff [NCHAN];
   logic [CSUM_W-1:0] coln_in [NCHAN];
   logic [CSUM_W-1:0] col_sum [NCHAN];
   logic [WSUM_W-1:0] win_sum [NCHAN];
   logic [CHAN_W-1:0] mean   [NCHAN];

   // Sum the arriving column and the window, per channel
   always_comb begin
      for (int k = 0; k < NCHAN; k++) begin
         col_sum[k] = (pos.use_above ? CSUM_W'(above_pix[k*CHAN_W +: CHAN_W]) : '0)
                    + (pos.use_mid   ? CSUM_W'(mid_pix[k*CHAN_W +: CHAN_W])   : '0)
                    + (pos.use_cur   ? CSUM_W'(cur_pix[k*CHAN_W +: CHAN_W])   : '0);
         win_sum[k] = WSUM_W'(colm_ff[k]) + WSUM_W'(coln_ff[k])
                    + (pos.col_first ? '0 : WSUM_W'(col_sum[k]));
         mean[k]    = div9(win_sum[k]);
         // At column zero the window restarts with the new column alone
         colm_in[k] = pos.col_first ? '0 : coln_ff[k];
         coln_in[k] = col_sum[k];
      end
   end

   // Shift the window on each advancing item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NCHAN; k++) begin
            colm_ff[k] <= '0;
            coln_ff[k] <= '0;
         end
      end else if (advance) begin
         for (int k = 0; k < NCHAN; k++) begin
            colm_ff[k] <= colm_in[k];
            coln_ff[k] <= coln_in[k];
         end
      end
   end

   assign mean_red   = mean[2];
   assign mean_green = mean[1];
   assign mean_blue  = mean[0];

endmodule

// ===== hw/rtl/box_blur_3x3_rgb.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 box mean filter over an RGB raster stream, with a two-row line store.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  kind, in_red, in_green, in_blue
//   rsp      out        rsp_valid/rsp_stall  out_red/green/blue/alpha, frame_last
//   csr      in         APB psel/penable     image_width (0x0), image_height (0x4)
//
// One item per cycle sustained while results are not stalled. An item passes
// through the line-store read stage; as it leaves that stage it updates the
// window and loads the result register, which holds it until transferred.
// A stalled result stops the read stage only when that stage holds an item
// that releases a result. Synchronous reset clears counters, window and
// valids and sets the size registers to defaults; the line store is not cleared.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH  = bbr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bbr_pkg::MAX_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // Input pixels
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_kind,
   input  logic [bbr_pkg::CHAN_W-1:0]     req_in_red,
   input  logic [bbr_pkg::CHAN_W-1:0]     req_in_green,
   input  logic [bbr_pkg::CHAN_W-1:0]     req_in_blue,
   // Filtered pixels
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bbr_pkg::CHAN_W-1:0]     rsp_out_red,
   output logic [bbr_pkg::CHAN_W-1:0]     rsp_out_green,
   output logic [bbr_pkg::CHAN_W-1:0]     rsp_out_blue,
   output logic [bbr_pkg::CHAN_W-1:0]     rsp_out_alpha,
   output logic                           rsp_frame_last,
   // Configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bbr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bbr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bbr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import bbr_pkg::*;

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int LINE_W = 2 * PIX_W;   // {above, middle}

   // Configuration registers
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             csr_write;
   logic [0:0]       csr_index;

   // Handshake and stage control
   logic             accept;
   logic             s1_adv;
   logic             s1_valid_ff, s1_valid_in;
   pos_type          s1_pos_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [COL_W-1:0] s1_addr_ff;
   pos_type          pos;
   logic [COL_W-1:0] col_addr;
   logic [PIX_W-1:0] req_pix;

   // Line store and same-address bypass
   logic [LINE_W-1:0] ram_rd_data;
   logic [LINE_W-1:0] line_wr_data;
   logic [LINE_W-1:0] line_rd;
   logic              fwd_ff;
   logic [LINE_W-1:0] fwd_data_ff;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;
   logic              last_ff;
   logic [CHAN_W-1:0] mean_red, mean_green, mean_blue;

   // Decode the configuration port
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_IMG_WIDTH:  width_in  = csr_pwdata[CFG_W-1:0];
            REG_IMG_HEIGHT: height_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_IMG_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMG_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Advance the read stage unless its result cannot be placed
   assign s1_adv    = s1_valid_ff && (!s1_pos_ff.emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;
   assign req_pix   = (req_kind == KIND_DRAIN) ? '0 : {req_in_red, req_in_green, req_in_blue};

   bbr_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock      (clock),
      .reset      (reset),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .restart    (csr_write),
      .advance    (accept),
      .col_addr   (col_addr),
      .pos        (pos)
   );

   // Hold the read stage
   assign s1_valid_in = accept || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff  <= pos;
         s1_pix_ff  <= req_pix;
         s1_addr_ff <= col_addr;
      end
   end

   // Line store: the middle row moves up, the new pixel becomes the middle row
   assign line_rd      = fwd_ff ? fwd_data_ff : ram_rd_data;
   assign line_wr_data = {line_rd[PIX_W-1:0], s1_pix_ff};

   bbr_ram #(
      .WIDTH   (LINE_W),
      .DEPTH   (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (line_wr_data),
      .rd_en   (accept),
      .rd_addr (col_addr),
      .rd_data (ram_rd_data)
   );

   // Bypass a write that lands on the address read in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (accept) begin
         fwd_ff <= s1_adv && (s1_addr_ff == col_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_data_ff <= line_wr_data;
      end
   end

   bbr_window u_window (
      .clock      (clock),
      .reset      (reset),
      .advance    (s1_adv),
      .pos        (s1_pos_ff),
      .above_pix  (line_rd[LINE_W-1:PIX_W]),
      .mid_pix    (line_rd[PIX_W-1:0]),
      .cur_pix    (s1_pix_ff),
      .mean_red   (mean_red),
      .mean_green (mean_green),
      .mean_blue  (mean_blue)
   );

   // Result register: load on a releasing advance, drop once transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_adv && s1_pos_ff.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_pos_ff.emit) begin
         red_ff   <= mean_red;
         green_ff <= mean_green;
         blue_ff  <= mean_blue;
         last_ff  <= s1_pos_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = red_ff;
   assign rsp_out_green  = green_ff;
   assign rsp_out_blue   = blue_ff;
   assign rsp_out_alpha  = ALPHA_OPAQUE;
   assign rsp_frame_last = last_ff;

`ifndef SYNTHESIS
   // A releasing advance always leaves a result behind
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_pos_ff.emit |=> rsp_valid_ff)
      else $error("result register not loaded after a releasing advance");

   // A new result only follows an item leaving the read stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without an item in the read stage");

   // The closing item of a frame returns the position to the origin
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && pos.last |=> (col_addr == '0) && pos.col_first)
      else $error("position not back at the origin after the frame end");

   // Bypass data is only taken while the read stage holds an item
   a_fwd_live: assert property (@(posedge clock) disable iff (reset)
      fwd_ff && s1_adv |-> s1_valid_ff)
      else $error("bypass used without an item in the read stage");
`endif

endmodule
